/* src/psq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psq_pkg
// shared types and codes of the priority slot queue
// ----------------------------------------------------------------------------
package psq_pkg;

    localparam int CMD_W  = 2;
    localparam int HELD_W = 5;
    localparam int CFG_W  = 5;
    localparam int CFG_IDX_W = 1;

    typedef logic [CMD_W-1:0] t_cmd;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cmd CMD_ENQUEUE = 2'd0;
    localparam t_cmd CMD_DEQUEUE = 2'd1;
    localparam t_cmd CMD_PEEK    = 2'd2;

    localparam t_cfg_idx CFG_SLOTS_IN_USE = 1'd0;
    localparam t_cfg_idx CFG_ORDER_MODE   = 1'd1;

endpackage
`default_nettype wire

/* src/psq_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psq_if
// valid/ready channels carrying command items in and result items out
// ----------------------------------------------------------------------------
interface psq_in_if #(
    parameter int PRIORITY_BITS = 16,
    parameter int PAYLOAD_BITS  = 32
);
    logic                     valid;
    logic                     ready;
    logic [psq_pkg::CMD_W-1:0] command;
    logic [PRIORITY_BITS-1:0] entry_priority;
    logic [PAYLOAD_BITS-1:0]  entry_payload;

    modport source (output valid, command, entry_priority, entry_payload, input ready);
    modport sink   (input valid, command, entry_priority, entry_payload, output ready);
endinterface

interface psq_out_if #(
    parameter int PRIORITY_BITS = 16,
    parameter int PAYLOAD_BITS  = 32
);
    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic [PRIORITY_BITS-1:0]  out_priority;
    logic [PAYLOAD_BITS-1:0]   out_payload;
    logic [psq_pkg::HELD_W-1:0] entries_held;
    logic                      is_empty;

    modport source (output valid, ok, out_priority, out_payload, entries_held, is_empty,
                    input ready);
    modport sink   (input valid, ok, out_priority, out_payload, entries_held, is_empty,
                    output ready);
endinterface
`default_nettype wire

/* src/priority_slot_queue_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// priority_slot_queue_unit
// slot-based priority queue: enqueue, dequeue best, peek best
// ----------------------------------------------------------------------------
// One command item is worked on at a time. Priorities and payloads live in a
// single-port synchronous memory of MAX_SLOTS entries, with a valid bit per
// slot in flip-flops. Enqueue walks the valid bits from slot 0 and writes
// the first free slot. Dequeue and peek read one slot per cycle from the
// memory and compare it against the best so far. An unused command code
// skips the scan and goes straight to the result. The finished result sits
// in an output register, so the next item is taken while it waits. Ties go
// to the lowest slot. Configuration must be written only while the block is
// idle; the block itself does not enforce this.
module priority_slot_queue_unit #(
    parameter int MAX_SLOTS     = 16,
    parameter int PRIORITY_BITS = 16,
    parameter int PAYLOAD_BITS  = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [psq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [psq_pkg::CFG_W-1:0]     i_cfg_data,
    psq_in_if.sink                       i_in,
    psq_out_if.source                    o_out
);
    import psq_pkg::*;

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int MW = PRIORITY_BITS + PAYLOAD_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LAST = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [CFG_W-1:0]         r_slots;
    logic                     r_order;
    logic [MAX_SLOTS-1:0]     r_valid;
    logic [CW-1:0]            r_count, n_count;

    t_cmd                     r_cmd;
    logic [PRIORITY_BITS-1:0] r_pri_in;
    logic [PAYLOAD_BITS-1:0]  r_pay_in;
    logic [CW-1:0]            r_idx;
    logic                     r_p_act;
    logic                     r_p_vld;
    logic [IW-1:0]            r_p_idx;
    logic [MW-1:0]            r_q;
    logic                     r_found;
    logic [PRIORITY_BITS-1:0] r_best_pri;
    logic [PAYLOAD_BITS-1:0]  r_best_pay;
    logic [IW-1:0]            r_best_idx;

    logic                     r_ovalid;
    logic                     r_ok;
    logic [PRIORITY_BITS-1:0] r_opri;
    logic [PAYLOAD_BITS-1:0]  r_opay;
    logic [HELD_W-1:0]        r_oheld;
    logic                     r_oempty;

    logic [MW-1:0]            mem [MAX_SLOTS];

    logic [CW-1:0]            w_usable;
    logic                     w_more;
    logic                     w_cur_valid;
    logic                     w_is_fetch;
    logic                     w_mem_we;
    logic                     w_better;
    logic                     w_take;
    logic                     w_out_free;
    logic                     w_accept;
    logic [PRIORITY_BITS-1:0] w_q_pri;
    logic [PAYLOAD_BITS-1:0]  w_q_pay;

    // capacity saturates at the number of physical slots
    always_comb begin
        if (32'(r_slots) > 32'(MAX_SLOTS)) begin
            w_usable = CW'(MAX_SLOTS);
        end else begin
            w_usable = CW'(r_slots);
        end
    end

    assign w_more      = r_idx < w_usable;
    assign w_cur_valid = r_valid[r_idx[IW-1:0]];
    assign w_is_fetch  = (r_cmd == CMD_DEQUEUE) || (r_cmd == CMD_PEEK);
    assign w_mem_we    = (r_state == S_SCAN) && (r_cmd == CMD_ENQUEUE) && w_more && !w_cur_valid;
    assign w_out_free  = !r_ovalid || o_out.ready;
    assign w_accept    = (r_state == S_IDLE) && i_in.valid;

    assign w_q_pri = r_q[MW-1:PAYLOAD_BITS];
    assign w_q_pay = r_q[PAYLOAD_BITS-1:0];
    // strict compare keeps the earlier (lower) slot on a tie
    assign w_better = !r_found || (r_order ? (w_q_pri < r_best_pri) : (w_q_pri > r_best_pri));
    assign w_take   = r_p_act && r_p_vld && w_better;

    always_comb begin
        n_count = r_count;
        if (w_is_fetch && (r_cmd == CMD_DEQUEUE) && r_found && (r_count != '0)) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if ((i_in.command == CMD_ENQUEUE) || (i_in.command == CMD_DEQUEUE) ||
                        (i_in.command == CMD_PEEK)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_cmd == CMD_ENQUEUE) begin
                    if (!w_more || !w_cur_valid) begin
                        n_state = S_DONE;
                    end
                end else if (!w_more) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // slot memory, one read or write port, registered read data
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_idx[IW-1:0]] <= {r_pri_in, r_pay_in};
        end
        r_q <= mem[r_idx[IW-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slots  <= CFG_W'(16);
            r_order  <= 1'b0;
            r_valid  <= '0;
            r_count  <= '0;
            r_p_act  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLOTS_IN_USE: r_slots <= i_cfg_data;
                    CFG_ORDER_MODE:   r_order <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_p_act <= 1'b0;
                end
                S_SCAN: begin
                    r_p_act <= (r_cmd != CMD_ENQUEUE) && w_more;
                    if (w_mem_we) begin
                        r_valid[r_idx[IW-1:0]] <= 1'b1;
                        r_count                <= r_count + CW'(1);
                    end
                end
                S_LAST: begin
                    r_p_act <= 1'b0;
                end
                S_DONE: begin
                    if (w_out_free && w_is_fetch && (r_cmd == CMD_DEQUEUE) && r_found) begin
                        r_valid[r_best_idx] <= 1'b0;
                        r_count             <= n_count;
                    end
                end
                default: begin
                    r_p_act <= 1'b0;
                end
            endcase
            if ((r_state == S_DONE) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // item data, scan pipeline and result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_in.command;
            r_pri_in <= i_in.entry_priority;
            r_pay_in <= i_in.entry_payload;
            r_idx    <= '0;
            r_found  <= 1'b0;
        end else begin
            if (r_state == S_SCAN) begin
                r_idx   <= r_idx + CW'(1);
                r_p_vld <= w_cur_valid;
                r_p_idx <= r_idx[IW-1:0];
            end
            if (w_mem_we || w_take) begin
                r_found <= 1'b1;
            end
        end
        if (w_take) begin
            r_best_pri <= w_q_pri;
            r_best_pay <= w_q_pay;
            r_best_idx <= r_p_idx;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_ok     <= r_found && ((r_cmd == CMD_ENQUEUE) || w_is_fetch);
            r_opri   <= (w_is_fetch && r_found) ? r_best_pri : '0;
            r_opay   <= (w_is_fetch && r_found) ? r_best_pay : '0;
            r_oheld  <= HELD_W'(n_count);
            r_oempty <= (n_count == '0);
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.ok           = r_ok;
    assign o_out.out_priority = r_opri;
    assign o_out.out_payload  = r_opay;
    assign o_out.entries_held = r_oheld;
    assign o_out.is_empty     = r_oempty;

endmodule
`default_nettype wire

/* src/psq_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psq_checker
// port-level checks of the priority slot queue results
// ----------------------------------------------------------------------------
module psq_checker #(
    parameter int PRIORITY_BITS = 16,
    parameter int PAYLOAD_BITS  = 32
) (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_out_valid,
    input wire                       i_out_ready,
    input wire                       i_ok,
    input wire [PRIORITY_BITS-1:0]   i_pri,
    input wire [PAYLOAD_BITS-1:0]    i_pay,
    input wire [psq_pkg::HELD_W-1:0] i_held,
    input wire                       i_empty
);
    import psq_pkg::*;

    logic [HELD_W-1:0] r_last_held;
    logic [HELD_W-1:0] w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_held <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_last_held <= i_held;
        end
    end

    assign w_step = i_held - r_last_held;

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_ok) && $stable(i_pri)
            && $stable(i_pay) && $stable(i_held) && $stable(i_empty))
        else $error("result item changed while stalled");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_empty == (i_held == '0)))
        else $error("empty flag disagrees with entry count");

    // a failed command (ok low) carries no entry
    a_no_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ok |-> (i_pri == '0) && (i_pay == '0))
        else $error("entry fields not zero on failed command");

    // each command moves the count by at most one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (w_step == HELD_W'(0)) || (w_step == HELD_W'(1))
            || (w_step == '1))
        else $error("entry count jumped between results");

endmodule

bind priority_slot_queue_unit psq_checker #(
    .PRIORITY_BITS (PRIORITY_BITS),
    .PAYLOAD_BITS  (PAYLOAD_BITS)
) u_psq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_ok        (o_out.ok),
    .i_pri       (o_out.out_priority),
    .i_pay       (o_out.out_payload),
    .i_held      (o_out.entries_held),
    .i_empty     (o_out.is_empty)
);
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the priority slot queue. Command items are
// predicted at acceptance by a behavioural copy of the slot array. Each
// result item is checked field by field against the oldest prediction.
// Directed items cover the empty queue, extreme fields, ties, both orders,
// the unused command code and odd capacities. Random traffic with idle
// gaps and output stalls follows.
// ----------------------------------------------------------------------------
module testbench;
    import psq_pkg::*;

    localparam int SLOT_COUNT    = 16;
    localparam int PRIO_W        = 16;
    localparam int PAY_W         = 32;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 30;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    // the package names no code for this one
    localparam t_cmd CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic              ok;
        logic [PRIO_W-1:0] prio;
        logic [PAY_W-1:0]  payload;
        logic [HELD_W-1:0] held;
        logic              empty;
    } queue_result_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    psq_in_if  #(.PRIORITY_BITS(PRIO_W), .PAYLOAD_BITS(PAY_W)) cmd_if ();
    psq_out_if #(.PRIORITY_BITS(PRIO_W), .PAYLOAD_BITS(PAY_W)) res_if ();

    priority_slot_queue_unit #(
        .MAX_SLOTS    (SLOT_COUNT),
        .PRIORITY_BITS(PRIO_W),
        .PAYLOAD_BITS (PAY_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (cmd_if),
        .o_out      (res_if)
    );

    always #5 i_clk = ~i_clk;

    // behavioural copy of the queue
    logic              slot_used [SLOT_COUNT];
    logic [PRIO_W-1:0] slot_prio [SLOT_COUNT];
    logic [PAY_W-1:0]  slot_tag  [SLOT_COUNT];
    int                held_count  = 0;
    logic [CFG_W-1:0]  cap_setting = CFG_W'(16);
    logic              min_first   = 1'b0;

    queue_result_t pending_results[$];
    int            fault_count  = 0;
    int            results_seen = 0;

    // sender and receiver pacing
    int          burst_left    = 0;
    bit          tx_gapless    = 1'b0;
    bit          rx_always     = 1'b0;
    bit          hold_request  = 1'b0;
    int          hold_left     = 0;
    int          pattern_age   = 0;
    logic [15:0] stall_pattern = '1;

    function automatic queue_result_t predict_queue_op(t_cmd cmd, logic [PRIO_W-1:0] prio,
                                                       logic [PAY_W-1:0] payload);
        queue_result_t r;
        int usable;
        int best;
        r = '0;
        usable = (cap_setting > SLOT_COUNT) ? SLOT_COUNT : int'(cap_setting);
        best = -1;
        if (cmd == CMD_ENQUEUE) begin
            for (int i = 0; i < usable; i++) begin
                if (!slot_used[i]) begin
                    slot_used[i] = 1'b1;
                    slot_prio[i] = prio;
                    slot_tag[i]  = payload;
                    held_count++;
                    r.ok = 1'b1;
                    break;
                end
            end
        end else if (cmd == CMD_DEQUEUE || cmd == CMD_PEEK) begin
            for (int i = 0; i < usable; i++) begin
                if (slot_used[i]) begin
                    if (best < 0)
                        best = i;
                    else if (min_first ? (slot_prio[i] < slot_prio[best])
                                       : (slot_prio[i] > slot_prio[best]))
                        best = i;
                end
            end
            if (best >= 0) begin
                r.ok      = 1'b1;
                r.prio    = slot_prio[best];
                r.payload = slot_tag[best];
                if (cmd == CMD_DEQUEUE) begin
                    slot_used[best] = 1'b0;
                    if (held_count > 0)
                        held_count--;
                end
            end
        end
        r.held  = HELD_W'(held_count);
        r.empty = (held_count == 0);
        return r;
    endfunction

    task automatic report_fault(string what);
        $display("ERROR at %0t ns: %s", $time, what);
        fault_count++;
    endtask

    task automatic send_command(t_cmd cmd, logic [PRIO_W-1:0] prio, logic [PAY_W-1:0] payload);
        int gap;
        if (burst_left == 0) begin
            gap = (tx_gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                cmd_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        cmd_if.valid          <= 1'b1;
        cmd_if.command        <= cmd;
        cmd_if.entry_priority <= prio;
        cmd_if.entry_payload  <= payload;
        do @(posedge i_clk); while (!cmd_if.ready);
        pending_results.push_back(predict_queue_op(cmd, prio, payload));
    endtask

    task automatic wait_queue_idle();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_register(t_cfg_idx idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_SLOTS_IN_USE)
            cap_setting = value;
        else
            min_first = value[0];
    endtask

    // receiver: long hold on request, else always ready or a rotating stall pattern
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (rx_always) begin
            res_if.ready <= 1'b1;
        end else begin
            if (pattern_age == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pattern = '1;
                    1: stall_pattern = 16'($urandom);
                    2: stall_pattern = 16'($urandom | $urandom);
                    default: stall_pattern = 16'($urandom & $urandom);
                endcase
                pattern_age = $urandom_range(16, 64);
            end
            pattern_age--;
            res_if.ready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    always @(posedge i_clk) begin : result_check
        queue_result_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_fault($sformatf("result %0d arrived with nothing pending",
                                       results_seen));
            end else begin
                want = pending_results.pop_front();
                if (res_if.ok !== want.ok)
                    report_fault($sformatf("result %0d ok: expected %0h got %0h",
                                           results_seen, want.ok, res_if.ok));
                if (res_if.out_priority !== want.prio)
                    report_fault($sformatf("result %0d priority: expected %0h got %0h",
                                           results_seen, want.prio, res_if.out_priority));
                if (res_if.out_payload !== want.payload)
                    report_fault($sformatf("result %0d payload: expected %0h got %0h",
                                           results_seen, want.payload, res_if.out_payload));
                if (res_if.entries_held !== want.held)
                    report_fault($sformatf("result %0d entries: expected %0d got %0d",
                                           results_seen, want.held, res_if.entries_held));
                if (res_if.is_empty !== want.empty)
                    report_fault($sformatf("result %0d empty flag: expected %0h got %0h",
                                           results_seen, want.empty, res_if.is_empty));
            end
        end
    end

    task automatic test_empty_queue();
        write_register(CFG_SLOTS_IN_USE, CFG_W'(4));
        write_register(CFG_ORDER_MODE, CFG_W'(0));
        send_command(CMD_PEEK, '0, '0);
        send_command(CMD_DEQUEUE, '0, '0);
        send_command(CMD_UNUSED, '1, '1);
    endtask

    task automatic test_fill_and_ties();
        send_command(CMD_ENQUEUE, 16'h0000, 32'h0000_0000);
        send_command(CMD_ENQUEUE, 16'hffff, 32'hffff_ffff);
        send_command(CMD_ENQUEUE, 16'hffff, 32'h1234_5678);
        send_command(CMD_ENQUEUE, 16'h8000, 32'ha5a5_a5a5);
        // no free slot left among the four in use
        send_command(CMD_ENQUEUE, 16'h1234, 32'h0000_0001);
        send_command(CMD_PEEK, '0, '0);
        send_command(CMD_DEQUEUE, '0, '0);
        send_command(CMD_DEQUEUE, '0, '0);
    endtask

    task automatic test_smallest_first();
        wait_queue_idle();
        write_register(CFG_ORDER_MODE, CFG_W'(1));
        send_command(CMD_PEEK, '0, '0);
        send_command(CMD_DEQUEUE, '0, '0);
        send_command(CMD_DEQUEUE, '0, '0);
        send_command(CMD_DEQUEUE, '0, '0);
    endtask

    task automatic test_capacity_edges();
        wait_queue_idle();
        write_register(CFG_SLOTS_IN_USE, CFG_W'(0));
        send_command(CMD_ENQUEUE, 16'h0042, 32'hdead_beef);
        send_command(CMD_PEEK, '0, '0);
        wait_queue_idle();
        write_register(CFG_SLOTS_IN_USE, CFG_W'(2));
        send_command(CMD_ENQUEUE, 16'h0007, 32'h0000_0007);
        send_command(CMD_ENQUEUE, 16'h0003, 32'h0000_0003);
        // shrink below what is held: slot 1 stays counted but hidden
        wait_queue_idle();
        write_register(CFG_SLOTS_IN_USE, CFG_W'(1));
        send_command(CMD_PEEK, '0, '0);
        send_command(CMD_DEQUEUE, '0, '0);
        send_command(CMD_PEEK, '0, '0);
        wait_queue_idle();
        write_register(CFG_SLOTS_IN_USE, CFG_W'(31));
        send_command(CMD_PEEK, '0, '0);
        send_command(CMD_ENQUEUE, 16'h5555, 32'h5555_aaaa);
    endtask

    task automatic test_output_stall();
        wait_queue_idle();
        write_register(CFG_SLOTS_IN_USE, CFG_W'(16));
        write_register(CFG_ORDER_MODE, CFG_W'(0));
        tx_gapless = 1'b1;
        @(posedge i_clk);
        hold_request = 1'b1;
        for (int n = 0; n < 24; n++)
            send_command((n % 3 == 2) ? CMD_DEQUEUE : CMD_ENQUEUE,
                         PRIO_W'($urandom), PAY_W'($urandom));
        tx_gapless = 1'b0;
    endtask

    task automatic test_random_traffic(int phases, int items_per_phase);
        int                enq_pct;
        int                r;
        t_cmd              cmd;
        logic [PRIO_W-1:0] prio;
        enq_pct = 0;
        for (int p = 0; p < phases; p++) begin
            wait_queue_idle();
            case ($urandom_range(0, 6))
                0: write_register(CFG_SLOTS_IN_USE, CFG_W'(1));
                1: write_register(CFG_SLOTS_IN_USE, CFG_W'(16));
                2: write_register(CFG_SLOTS_IN_USE, CFG_W'(31));
                3: write_register(CFG_SLOTS_IN_USE, CFG_W'(17));
                4: write_register(CFG_SLOTS_IN_USE, CFG_W'(2));
                default: write_register(CFG_SLOTS_IN_USE, CFG_W'($urandom_range(3, 15)));
            endcase
            write_register(CFG_ORDER_MODE, CFG_W'($urandom_range(0, 1)));
            tx_gapless = ($urandom_range(0, 3) == 0);
            rx_always  = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < items_per_phase; n++) begin
                // alternate filling runs and draining runs
                if (n % 32 == 0)
                    enq_pct = ((n / 32) % 2 == 0) ? 85 : 20;
                r = $urandom_range(0, 99);
                if (r < 3)
                    cmd = CMD_UNUSED;
                else if (r < 18)
                    cmd = CMD_PEEK;
                else if (r < 18 + enq_pct * 82 / 100)
                    cmd = CMD_ENQUEUE;
                else
                    cmd = CMD_DEQUEUE;
                case ($urandom_range(0, 3))
                    0: prio = PRIO_W'($urandom_range(0, 7));
                    1: prio = $urandom_range(0, 1) ? '1 : '0;
                    default: prio = PRIO_W'($urandom);
                endcase
                send_command(cmd, prio, PAY_W'($urandom));
            end
        end
        tx_gapless = 1'b0;
        rx_always  = 1'b0;
    endtask

    initial begin
        cmd_if.valid          = 1'b0;
        cmd_if.command        = CMD_ENQUEUE;
        cmd_if.entry_priority = '0;
        cmd_if.entry_payload  = '0;
        res_if.ready          = 1'b0;
        foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_prio[i] = '0;
            slot_tag[i]  = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_fill_and_ties();
        test_smallest_first();
        test_capacity_edges();
        test_output_stall();
        test_random_traffic(9, 64);

        wait_queue_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
